FILE: design/assert_macros.svh
// assertion macros for the checker file of the safety checker
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BSC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bsc_pkg.sv
// shared constants, codes, types and width helpers of the safety checker
// no dependencies; imported by every module of the block
package bsc_pkg;

  localparam int PROCS_DEF = 8;
  localparam int RES_DEF   = 4;
  localparam int NREG      = 4;
  localparam int CFG_AW    = 2;
  localparam int MAX_OUT   = 8;
  localparam int OW        = 3;

  localparam int MODE_W  = 2;
  localparam int PROC_FW = 3;
  localparam int RIDX_FW = 2;
  localparam int AMT_W   = 8;
  localparam int STAT_W  = 2;

  // stored widths: allocation may grow past one byte through requests
  // granted against a need that predates a later allocation load
  localparam int MAX_W   = 8;
  localparam int ALLOC_W = 9;
  localparam int NEED_W  = 10;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;
  localparam int OFS_PROC    = 0;
  localparam int OFS_RIDX    = 3;
  localparam int OFS_AMT     = 5;
  localparam int OFS_REQ     = 13;

  localparam logic [MODE_W-1:0] MODE_LD_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LD_MAX   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REQUEST  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_SAFE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNSAFE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;

  typedef struct packed {
    logic fits;
    logic req_ok;
  } eval_stat_t;

  // signed width of work and available: holds -procs*510 .. 255+procs*510
  function automatic int wrk_width(input int procs);
    return $clog2(procs + 1) + ALLOC_W + 1;
  endfunction

endpackage

FILE: design/bankers_safety_checker.sv
// top level of the deadlock-avoidance safety checker: sequencer, vectors, result register
// depends on bsc_pkg, bsc_row_mem (allocation rows, max/need rows), bsc_row_eval
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  in_      | slave     | in_tvalid / in_tready  | tuser: mode; tdata: proc, res_index,
//           |           |                        |   amount, req_amount_0..3
//  out_     | master    | out_tvalid / out_tready| tuser: status; tdata: order_proc; tlast
//  cfg_     | write     | cfg_wr_en              | cfg_addr selects total_res_N, cfg_wdata
//
// load item: row read, then row write back
// start item: a sweep over all rows derives need and available, then the check
// check: each pass reads all PROCS rows, at most PROCS passes (one memory row per cycle)
// results: one per cycle when out_tready stays high, min(PROCS,8) for a safe order
// request item: row read, checks against need and available, the check, a rollback state if unsafe
// reset is synchronous; rows never written read as zero, no clearing pass
// a stalled result blocks the sequencer; the next item is taken once the last
// result of the current one sits in the output register
module bankers_safety_checker import bsc_pkg::*; #(
  parameter int PROCS     = PROCS_DEF,
  parameter int RESOURCES = RES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tuser: mode[1:0]
  // in_tdata: proc[2:0], res_index[4:3], amount[12:5], req_amount_0[20:13],
  //           req_amount_1[28:21], req_amount_2[36:29], req_amount_3[44:37], zero fill
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]      in_tuser,
  // out_tuser: status[1:0]
  // out_tdata: order_proc[2:0], zero fill
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]      out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [AMT_W-1:0]       cfg_wdata
);
  localparam int PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int CW    = $clog2(PROCS + 1);
  localparam int RW    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int NOUT  = (PROCS < MAX_OUT) ? PROCS : MAX_OUT;
  localparam int WRK_W = wrk_width(PROCS);
  localparam int MA_W  = RESOURCES * ALLOC_W;
  localparam int MB_W  = RESOURCES * (MAX_W + NEED_W);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LD_WR    = 3'd1;
  localparam logic [2:0] S_ST_SWEEP = 3'd2;
  localparam logic [2:0] S_RQ_CHK   = 3'd3;
  localparam logic [2:0] S_CHK_INIT = 3'd4;
  localparam logic [2:0] S_CHECK    = 3'd5;
  localparam logic [2:0] S_ROLLBACK = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  // ---------------- input fields ----------------
  logic [MODE_W-1:0]                  in_mode;
  logic [PROC_FW-1:0]                 in_proc;
  logic [RIDX_FW-1:0]                 in_ridx;
  logic [AMT_W-1:0]                   in_amt;
  logic [RESOURCES-1:0][AMT_W-1:0]    in_req;
  logic                               acc;
  logic                               proc_ok;
  logic                               ridx_ok;

  assign in_mode = in_tuser;
  assign in_proc = in_tdata[OFS_PROC +: PROC_FW];
  assign in_ridx = in_tdata[OFS_RIDX +: RIDX_FW];
  assign in_amt  = in_tdata[OFS_AMT +: AMT_W];
  assign acc     = in_tvalid && in_tready;
  assign proc_ok = int'(in_proc) < PROCS;
  assign ridx_ok = int'(in_ridx) < RESOURCES;

  // ---------------- configured totals ----------------
  logic [NREG-1:0][AMT_W-1:0]      total_r;
  logic [RESOURCES-1:0][WRK_W-1:0] tot_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_wr_en) begin
      total_r[cfg_addr] <= cfg_wdata;
    end
  end

  // resource types past the register list have no request field and a zero total
  for (genvar g = 0; g < RESOURCES; g++) begin : g_res
    if (g < NREG) begin : g_fld
      assign in_req[g]  = in_tdata[OFS_REQ + g*AMT_W +: AMT_W];
      assign tot_ext[g] = {{(WRK_W-AMT_W){1'b0}}, total_r[g]};
    end else begin : g_zero
      assign in_req[g]  = '0;
      assign tot_ext[g] = '0;
    end
  end

  // ---------------- state ----------------
  logic [2:0]                         state_r, state_nxt;
  logic [CW-1:0]                      addr_r;        // row read pointer
  logic                               ev_vld_r;      // read data of ev_p_r is valid
  logic [PW-1:0]                      ev_p_r;
  logic [PROCS-1:0]                   fin_r;
  logic [CW-1:0]                      done_r;
  logic                               found_r;       // a grant in the current pass
  logic [RESOURCES-1:0][WRK_W-1:0]    work_r;
  logic [RESOURCES-1:0][WRK_W-1:0]    avail_r;
  logic                               ld_alloc_r;
  logic                               ld_ok_r;
  logic [RW-1:0]                      ld_ridx_r;
  logic [AMT_W-1:0]                   ld_amt_r;
  logic [PW-1:0]                      row_p_r;       // row of a load or request
  logic [RESOURCES-1:0][AMT_W-1:0]    req_r;
  logic                               rq_act_r;      // tentative grant to undo if unsafe
  logic [MA_W-1:0]                    sv_a_r;
  logic [MB_W-1:0]                    sv_b_r;
  logic [STAT_W-1:0]                  kind_r;
  logic [OW-1:0]                      emit_cnt_r;
  logic [PROC_FW-1:0]                 order_r [MAX_OUT];
  logic                               out_vld_r;
  logic [STAT_W-1:0]                  out_stat_r;
  logic [PROC_FW-1:0]                 out_proc_r;
  logic                               out_last_r;

  // ---------------- memories ----------------
  logic                               rd_en;
  logic [PW-1:0]                      rd_addr;
  logic                               we_a, we_b;
  logic [PW-1:0]                      wr_addr;
  logic [MA_W-1:0]                    wd_a, rd_a;
  logic [MB_W-1:0]                    wd_b, rd_b;

  bsc_row_mem #(.DEPTH(PROCS), .WIDTH(MA_W)) u_alloc_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wd_a),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_a)
  );

  // row layout: need entries above max entries
  bsc_row_mem #(.DEPTH(PROCS), .WIDTH(MB_W)) u_maxneed_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wd_b),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_b)
  );

  logic [RESOURCES-1:0][ALLOC_W-1:0]  alloc_row, ld_alloc_row, alloc_req;
  logic [RESOURCES-1:0][MAX_W-1:0]    max_row, ld_max_row;
  logic [RESOURCES-1:0][NEED_W-1:0]   need_row, need_calc, need_req;
  logic [RESOURCES-1:0][WRK_W-1:0]    work_add;
  eval_stat_t                         stat;

  assign alloc_row = rd_a;
  assign max_row   = rd_b[RESOURCES*MAX_W-1:0];
  assign need_row  = rd_b[MB_W-1 -: RESOURCES*NEED_W];

  bsc_row_eval #(.PROCS(PROCS), .RESOURCES(RESOURCES)) u_eval (
    .alloc_row (alloc_row),
    .max_row   (max_row),
    .need_row  (need_row),
    .work_vec  (work_r),
    .avail_vec (avail_r),
    .req_vec   (req_r),
    .stat      (stat),
    .work_add  (work_add),
    .need_calc (need_calc),
    .alloc_req (alloc_req),
    .need_req  (need_req)
  );

  // ---------------- check step ----------------
  logic          grant;
  logic [CW-1:0] done_inc;
  logic          all_done;
  logic          pass_end;
  logic          pass_found;
  logic          out_load;
  logic          e_last;

  assign grant      = ev_vld_r && !fin_r[ev_p_r] && stat.fits;
  assign done_inc   = done_r + {{(CW-1){1'b0}}, grant};
  assign all_done   = (done_inc == CW'(PROCS));
  assign pass_end   = ev_vld_r && (ev_p_r == PW'(PROCS - 1));
  assign pass_found = found_r || grant;
  assign out_load   = !out_vld_r || out_tready;
  assign e_last     = (kind_r != STAT_SAFE) || (emit_cnt_r == OW'(NOUT - 1));

  // single-entry edits for matrix loads
  always_comb begin
    ld_alloc_row = alloc_row;
    ld_max_row   = max_row;
    ld_alloc_row[ld_ridx_r] = {{(ALLOC_W-AMT_W){1'b0}}, ld_amt_r};
    ld_max_row[ld_ridx_r]   = ld_amt_r;
  end

  // ---------------- sequencer and memory strobes ----------------
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    wr_addr   = row_p_r;
    wd_a      = rd_a;
    wd_b      = rd_b;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_mode != MODE_START && proc_ok) begin
            rd_en   = 1'b1;
            rd_addr = PW'(in_proc);
          end
          case (in_mode)
            MODE_LD_ALLOC: state_nxt = S_LD_WR;
            MODE_LD_MAX:   state_nxt = S_LD_WR;
            MODE_START:    state_nxt = S_ST_SWEEP;
            MODE_REQUEST:  state_nxt = proc_ok ? S_RQ_CHK : S_EMIT;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_WR: begin
        if (ld_ok_r) begin
          we_a = ld_alloc_r;
          we_b = !ld_alloc_r;
          wd_a = ld_alloc_row;
          wd_b = {need_row, ld_max_row};
        end
        state_nxt = S_IDLE;
      end
      S_ST_SWEEP: begin
        // read row addr_r while the previous row gets its need written
        if (int'(addr_r) < PROCS) begin
          rd_en   = 1'b1;
          rd_addr = addr_r[PW-1:0];
        end
        if (ev_vld_r) begin
          we_b    = 1'b1;
          wr_addr = ev_p_r;
          wd_b    = {need_calc, max_row};
        end
        if (pass_end) begin
          state_nxt = S_CHK_INIT;
        end
      end
      S_RQ_CHK: begin
        if (stat.req_ok) begin
          we_a      = 1'b1;
          we_b      = 1'b1;
          wd_a      = alloc_req;
          wd_b      = {need_req, max_row};
          state_nxt = S_CHK_INIT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_CHK_INIT: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        rd_en   = 1'b1;
        rd_addr = addr_r[PW-1:0];
        if (ev_vld_r && all_done) begin
          state_nxt = S_EMIT;
        end else if (pass_end && !pass_found) begin
          state_nxt = rq_act_r ? S_ROLLBACK : S_EMIT;
        end
      end
      S_ROLLBACK: begin
        we_a      = 1'b1;
        we_b      = 1'b1;
        wd_a      = sv_a_r;
        wd_b      = sv_b_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load && e_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ev_vld_r <= 1'b0;
      avail_r  <= '0;
      rq_act_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= rd_en;
      ev_p_r   <= rd_addr;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            row_p_r    <= PW'(in_proc);
            ld_alloc_r <= (in_mode == MODE_LD_ALLOC);
            ld_ok_r    <= proc_ok && ridx_ok;
            ld_ridx_r  <= RW'(in_ridx);
            ld_amt_r   <= in_amt;
            req_r      <= in_req;
            addr_r     <= '0;
            emit_cnt_r <= '0;
            kind_r     <= STAT_REJECT;
            rq_act_r   <= (in_mode == MODE_REQUEST);
            if (in_mode == MODE_START) begin
              avail_r <= tot_ext;
            end
          end
        end
        S_ST_SWEEP: begin
          if (rd_en) begin
            addr_r <= addr_r + 1'b1;
          end
          // available = total minus the column sums of allocation
          if (ev_vld_r) begin
            for (int r = 0; r < RESOURCES; r++) begin
              avail_r[r] <= avail_r[r] - {{(WRK_W-ALLOC_W){1'b0}}, alloc_row[r]};
            end
          end
        end
        S_RQ_CHK: begin
          if (stat.req_ok) begin
            for (int r = 0; r < RESOURCES; r++) begin
              avail_r[r] <= avail_r[r] - {{(WRK_W-AMT_W){1'b0}}, req_r[r]};
            end
            sv_a_r <= rd_a;
            sv_b_r <= rd_b;
          end
        end
        S_CHK_INIT: begin
          work_r  <= avail_r;
          fin_r   <= '0;
          done_r  <= '0;
          found_r <= 1'b0;
          addr_r  <= '0;
        end
        S_CHECK: begin
          addr_r <= (addr_r == CW'(PROCS - 1)) ? '0 : addr_r + 1'b1;
          if (grant) begin
            work_r         <= work_add;
            fin_r[ev_p_r]  <= 1'b1;
            done_r         <= done_inc;
            if (int'(done_r) < MAX_OUT) begin
              order_r[OW'(done_r)] <= PROC_FW'(ev_p_r);
            end
          end
          if (pass_end) begin
            found_r <= 1'b0;
          end else if (grant) begin
            found_r <= 1'b1;
          end
          kind_r <= (ev_vld_r && all_done) ? STAT_SAFE : STAT_UNSAFE;
        end
        S_ROLLBACK: begin
          for (int r = 0; r < RESOURCES; r++) begin
            avail_r[r] <= avail_r[r] + {{(WRK_W-AMT_W){1'b0}}, req_r[r]};
          end
        end
        S_EMIT: begin
          if (out_load && !e_last) begin
            emit_cnt_r <= emit_cnt_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == S_EMIT && out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_load) begin
      out_stat_r <= kind_r;
      out_proc_r <= (kind_r == STAT_SAFE) ? order_r[emit_cnt_r] : '0;
      out_last_r <= e_last;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-PROC_FW){1'b0}}, out_proc_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: design/bsc_row_mem.sv
// one row per process, synchronous read: data follows in the cycle after re
// depends on bsc_pkg; rows never written read as zero
module bsc_row_mem import bsc_pkg::*; #(
  parameter int DEPTH = PROCS_DEF,
  parameter int WIDTH = 8,
  localparam int AW_P = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [AW_P-1:0]       waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW_P-1:0]       raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  // per-row valid flags stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: design/bsc_row_eval.sv
// row arithmetic: fit test against work, need derivation, request checks
// depends on bsc_pkg; purely combinational, one process row at a time
module bsc_row_eval import bsc_pkg::*; #(
  parameter int PROCS     = PROCS_DEF,
  parameter int RESOURCES = RES_DEF,
  localparam int WRK_W    = wrk_width(PROCS)
) (
  input  logic [RESOURCES-1:0][ALLOC_W-1:0] alloc_row,
  input  logic [RESOURCES-1:0][MAX_W-1:0]   max_row,
  input  logic [RESOURCES-1:0][NEED_W-1:0]  need_row,
  input  logic [RESOURCES-1:0][WRK_W-1:0]   work_vec,
  input  logic [RESOURCES-1:0][WRK_W-1:0]   avail_vec,
  input  logic [RESOURCES-1:0][AMT_W-1:0]   req_vec,
  output eval_stat_t                        stat,
  output logic [RESOURCES-1:0][WRK_W-1:0]   work_add,
  output logic [RESOURCES-1:0][NEED_W-1:0]  need_calc,
  output logic [RESOURCES-1:0][ALLOC_W-1:0] alloc_req,
  output logic [RESOURCES-1:0][NEED_W-1:0]  need_req
);

  always_comb begin
    stat.fits   = 1'b1;
    stat.req_ok = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      // need and work are signed; a negative need fits unless work is lower still
      if ($signed(need_row[r]) > $signed(work_vec[r])) begin
        stat.fits = 1'b0;
      end
      if ($signed({{(NEED_W-AMT_W){1'b0}}, req_vec[r]}) > $signed(need_row[r])) begin
        stat.req_ok = 1'b0;
      end
      if ($signed({{(WRK_W-AMT_W){1'b0}}, req_vec[r]}) > $signed(avail_vec[r])) begin
        stat.req_ok = 1'b0;
      end
      work_add[r]  = work_vec[r] + {{(WRK_W-ALLOC_W){1'b0}}, alloc_row[r]};
      need_calc[r] = {{(NEED_W-MAX_W){1'b0}}, max_row[r]}
                   - {{(NEED_W-ALLOC_W){1'b0}}, alloc_row[r]};
      alloc_req[r] = alloc_row[r] + {{(ALLOC_W-AMT_W){1'b0}}, req_vec[r]};
      need_req[r]  = need_row[r] - {{(NEED_W-AMT_W){1'b0}}, req_vec[r]};
    end
  end

endmodule

FILE: design/bsc_checker.sv
// port-level checks of the safety checker, bound to the top level
// depends on bsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module bsc_checker import bsc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser,
  input logic                   out_tlast
);

  // a stalled result holds
  `BSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // the sequencer is busy in the cycle after it takes an item
  `BSC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken on two cycles in a row")

  // unsafe and rejected outcomes are a single result with a zero process
  `BSC_ASSERT(a_single_result, clk, rst_n, out_tvalid && (out_tuser != STAT_SAFE) |-> out_tlast && (out_tdata == '0), "unsafe or reject result not alone")

  `BSC_ASSERT(a_status_code, clk, rst_n, out_tvalid |-> (out_tuser == STAT_SAFE || out_tuser == STAT_UNSAFE || out_tuser == STAT_REJECT), "undefined status code")

endmodule

bind bankers_safety_checker bsc_checker u_bsc_checker (.*);

FILE: bench/bankers_safety_checker_tb.sv
// self-checking bench for bankers_safety_checker: directed table, then random phases
// predicts safe orders, unsafe verdicts and request rejections from its own copy of the state
// depends on bsc_pkg and the bankers_safety_checker rtl only
module bankers_safety_checker_tb;
  import bsc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int N_PROCS        = PROCS_DEF;
  localparam int N_RES          = RES_DEF;
  localparam int RAND_ITEMS     = 205;
  localparam int CALM_ITEMS     = 30;    // tail of the random part with no idling
  localparam int SETTLE_CYCLES  = 16;    // a load may still be in flight after the last result
  localparam int TAIL_CYCLES    = 40;
  localparam int HOLD_AT_RESULT = 150;   // result count that triggers the long back-pressure
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int MAX_PRINTS     = 40;
  localparam int DIR_ROWS       = 23;

  // configuration register base index; one register per resource total
  localparam logic [CFG_AW-1:0] REG_TOTAL_RES_0 = '0;

  // one input transfer, field by field
  typedef struct packed {
    logic [MODE_W-1:0]               mode;
    logic [PROC_FW-1:0]              proc;
    logic [RIDX_FW-1:0]              res_index;
    logic [AMT_W-1:0]                amount;
    logic [N_RES-1:0][AMT_W-1:0]     req;
  } bank_item_t;

  // one result transfer
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PROC_FW-1:0] order_proc;
    logic               is_last;
  } verdict_t;

  // how a row of the directed table is checked, or a totals write between rows
  typedef enum logic [2:0] {
    CHK_MODEL,     // predictor decides
    CHK_SAFE_ID,   // safe order 0,1,...,PROCS-1
    CHK_UNSAFE,    // single unsafe verdict
    CHK_REJECT,    // single rejection
    ROW_TOTALS     // write all totals from the req fields
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    bank_item_t item;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_wr_en;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [AMT_W-1:0]       cfg_wdata;

  bankers_safety_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // bench copy of the allocator state; derived values kept as plain signed ints
  logic [AMT_W-1:0] total_units [NREG];
  int               alloc_units [N_PROCS][N_RES];
  int               max_units   [N_PROCS][N_RES];
  int               need_units  [N_PROCS][N_RES];
  int               free_units  [N_RES];

  verdict_t  pending_verdicts [$];   // expected results, oldest first
  verdict_t  fresh_verdicts   [$];   // results of the item just predicted
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        results_seen   = 0;
  bit        calm           = 1'b0;  // no idling on either side
  bit        gappy          = 1'b1;  // sender may idle in this phase
  plan_row_t plan [DIR_ROWS];

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // safety sweep: repeated passes in process order, work grows as processes finish
  task automatic find_safe_order(output bit safe);
    int                 work [N_RES];
    int                 seq_pos [N_PROCS];
    bit [N_PROCS-1:0]   done_mask;
    int                 n_done;
    bit                 found;
    bit                 fits;
    for (int r = 0; r < N_RES; r++) work[r] = free_units[r];
    done_mask = '0;
    n_done    = 0;
    safe      = 1'b1;
    while (n_done < N_PROCS && safe) begin
      found = 1'b0;
      for (int p = 0; p < N_PROCS; p++) begin
        if (!done_mask[p]) begin
          fits = 1'b1;
          // a negative need fits unless work is lower still
          for (int r = 0; r < N_RES; r++)
            if (need_units[p][r] > work[r]) fits = 1'b0;
          if (fits) begin
            for (int r = 0; r < N_RES; r++) work[r] += alloc_units[p][r];
            done_mask[p]     = 1'b1;
            seq_pos[n_done]  = p;
            n_done++;
            found = 1'b1;
          end
        end
      end
      if (!found) safe = 1'b0;
    end
    if (!safe)
      fresh_verdicts.push_back('{status: STAT_UNSAFE, order_proc: '0, is_last: 1'b1});
    else
      // order is cut after MAX_OUT entries
      for (int k = 0; k < N_PROCS && k < MAX_OUT; k++)
        fresh_verdicts.push_back('{status: STAT_SAFE, order_proc: PROC_FW'(seq_pos[k]),
                                   is_last: (k == N_PROCS - 1) || (k == MAX_OUT - 1)});
  endtask

  // applies one accepted item to the bench state and collects its results
  task automatic predict_grant(input bank_item_t it);
    int p;
    int ri;
    int sum;
    bit reject;
    bit safe;
    fresh_verdicts.delete();
    p  = int'(it.proc);
    ri = int'(it.res_index);
    case (it.mode)
      MODE_LD_ALLOC: begin
        if (p < N_PROCS && ri < N_RES) alloc_units[p][ri] = int'(it.amount);
      end
      MODE_LD_MAX: begin
        if (p < N_PROCS && ri < N_RES) max_units[p][ri] = int'(it.amount);
      end
      MODE_START: begin
        for (int r = 0; r < N_RES; r++) begin
          sum = 0;
          for (int q = 0; q < N_PROCS; q++) begin
            need_units[q][r] = max_units[q][r] - alloc_units[q][r];
            sum += alloc_units[q][r];
          end
          free_units[r] = ((r < NREG) ? int'(total_units[r]) : 0) - sum;
        end
        find_safe_order(safe);
      end
      default: begin
        // request: bound check, then need and available, then tentative grant
        reject = (p >= N_PROCS);
        if (!reject)
          for (int r = 0; r < N_RES; r++)
            if (int'(it.req[r]) > need_units[p][r] || int'(it.req[r]) > free_units[r])
              reject = 1'b1;
        if (reject) begin
          fresh_verdicts.push_back('{status: STAT_REJECT, order_proc: '0, is_last: 1'b1});
        end else begin
          for (int r = 0; r < N_RES; r++) begin
            free_units[r]     -= int'(it.req[r]);
            alloc_units[p][r] += int'(it.req[r]);
            need_units[p][r]  -= int'(it.req[r]);
          end
          find_safe_order(safe);
          if (!safe)
            // unsafe: roll the grant back
            for (int r = 0; r < N_RES; r++) begin
              free_units[r]     += int'(it.req[r]);
              alloc_units[p][r] -= int'(it.req[r]);
              need_units[p][r]  += int'(it.req[r]);
            end
        end
      end
    endcase
  endtask

  // offers one item until the transfer, then queues its expected results
  task automatic send_item(input bank_item_t it, input row_kind_t kind);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[OFS_PROC +: PROC_FW] = it.proc;
    word[OFS_RIDX +: RIDX_FW] = it.res_index;
    word[OFS_AMT  +: AMT_W]   = it.amount;
    for (int r = 0; r < N_RES; r++) word[OFS_REQ + r * AMT_W +: AMT_W] = it.req[r];
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    // the predictor always runs so its state follows the block
    predict_grant(it);
    case (kind)
      CHK_SAFE_ID:
        for (int k = 0; k < N_PROCS && k < MAX_OUT; k++)
          pending_verdicts.push_back('{status: STAT_SAFE, order_proc: PROC_FW'(k),
                                       is_last: (k == N_PROCS - 1) || (k == MAX_OUT - 1)});
      CHK_UNSAFE:
        pending_verdicts.push_back('{status: STAT_UNSAFE, order_proc: '0, is_last: 1'b1});
      CHK_REJECT:
        pending_verdicts.push_back('{status: STAT_REJECT, order_proc: '0, is_last: 1'b1});
      default:
        foreach (fresh_verdicts[i]) pending_verdicts.push_back(fresh_verdicts[i]);
    endcase
    // sender idle burst
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // totals change only with the block idle: all results back and loads settled
  task automatic write_totals(input logic [N_RES-1:0][AMT_W-1:0] tv);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < NREG; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= REG_TOTAL_RES_0 + CFG_AW'(i);
      cfg_wdata <= tv[i];
      @(posedge clk);
      total_units[i] = tv[i];
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic plan_row_t entry(input row_kind_t k, input logic [MODE_W-1:0] m,
                                      input int p, input int ri, input int amt,
                                      input int a0, input int a1, input int a2, input int a3);
    plan_row_t e;
    e.kind           = k;
    e.item.mode      = m;
    e.item.proc      = PROC_FW'(p);
    e.item.res_index = RIDX_FW'(ri);
    e.item.amount    = AMT_W'(amt);
    e.item.req       = {AMT_W'(a3), AMT_W'(a2), AMT_W'(a1), AMT_W'(a0)};
    return e;
  endfunction

  // one random phase: new totals, a few matrix loads, a start, then requests mixed with loads and starts
  task automatic random_phase();
    logic [N_RES-1:0][AMT_W-1:0] tv;
    bank_item_t it;
    int n_loads;
    int n_reqs;
    int lim;
    int base;
    for (int r = 0; r < N_RES; r++)
      case ($urandom_range(0, 5))
        0:       tv[r] = '0;
        1:       tv[r] = '1;
        default: tv[r] = AMT_W'($urandom_range(0, 255));
      endcase
    write_totals(tv);
    gappy   = ($urandom_range(0, 2) != 0);
    n_loads = $urandom_range(3, 10);
    for (int i = 0; i < n_loads; i++) begin
      it           = '0;
      it.proc      = PROC_FW'($urandom_range(0, N_PROCS - 1));
      it.res_index = RIDX_FW'($urandom_range(0, N_RES - 1));
      it.mode      = ($urandom_range(0, 1) != 0) ? MODE_LD_ALLOC : MODE_LD_MAX;
      // ignored by loads
      for (int r = 0; r < N_RES; r++) it.req[r] = AMT_W'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) begin
        it.amount = AMT_W'($urandom_range(0, 255));
      end else if (it.mode == MODE_LD_ALLOC) begin
        // keep column sums mostly under the total
        it.amount = AMT_W'($urandom_range(0, int'(tv[it.res_index]) / 10));
      end else begin
        base = alloc_units[it.proc][it.res_index];
        if (base > 255) base = 255;
        base += $urandom_range(0, int'(tv[it.res_index]) / 3);
        it.amount = AMT_W'((base > 255) ? 255 : base);
      end
      send_item(it, CHK_MODEL);
    end
    it      = '0;
    it.mode = MODE_START;
    send_item(it, CHK_MODEL);
    n_reqs = $urandom_range(3, 8);
    for (int i = 0; i < n_reqs; i++) begin
      it           = '0;
      it.mode      = MODE_REQUEST;
      it.proc      = PROC_FW'($urandom_range(0, N_PROCS - 1));
      it.res_index = RIDX_FW'($urandom_range(0, N_RES - 1));
      it.amount    = AMT_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1: begin
          // noise, mostly rejected
          for (int r = 0; r < N_RES; r++) it.req[r] = AMT_W'($urandom_range(0, 255));
        end
        2: begin
          // stale need: a load between start and request
          it.mode = MODE_LD_MAX;
        end
        3: it.mode = MODE_START;
        default: begin
          // well-formed: within need and available, safety decides
          for (int r = 0; r < N_RES; r++) begin
            lim = (need_units[it.proc][r] < free_units[r]) ? need_units[it.proc][r]
                                                           : free_units[r];
            if (lim > 255) lim = 255;
            it.req[r] = (lim <= 0) ? '0 : AMT_W'($urandom_range(0, lim));
          end
        end
      endcase
      send_item(it, CHK_MODEL);
    end
  endtask

  // result side: checks each transfer against the oldest expectation, shapes out_tready
  initial begin : result_sink
    int       stall_left;
    int       run_left;
    int       hold_left;
    bit       hold_done;
    bit       rdy;
    verdict_t want;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: status %0d proc %0d last %0b",
                                  out_tuser, out_tdata[PROC_FW-1:0], out_tlast));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tuser !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", out_tuser, want.status));
          if (out_tdata[PROC_FW-1:0] !== want.order_proc)
            flag_mismatch($sformatf("order_proc %0d, wanted %0d",
                                    out_tdata[PROC_FW-1:0], want.order_proc));
          if (out_tlast !== want.is_last)
            flag_mismatch($sformatf("last %0b, wanted %0b", out_tlast, want.is_last));
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (calm) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        rdy = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            stall_left = $urandom_range(1, 12) - 1;
            rdy        = 1'b0;
          end
          1: begin
            run_left = $urandom_range(20, 60);   // stretch with no stall
            rdy      = 1'b1;
          end
          default: begin
            run_left = $urandom_range(1, 12) - 1;
            rdy      = 1'b1;
          end
        endcase
      end
      out_tready <= rdy;
    end
  end

  // stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    int rand_start;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_LD_ALLOC;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_TOTAL_RES_0;
    cfg_wdata <= '0;
    for (int i = 0; i < NREG; i++) total_units[i] = '0;
    for (int r = 0; r < N_RES; r++) begin
      free_units[r] = 0;
      for (int p = 0; p < N_PROCS; p++) begin
        alloc_units[p][r] = 0;
        max_units[p][r]   = 0;
        need_units[p][r]  = 0;
      end
    end
    // typed verdicts only where obvious: zero state, full totals, plain rejections
    plan = '{
      // request before any start: need and available are zero, all-zero request passes
      entry(CHK_SAFE_ID, MODE_REQUEST, 0, 0, 0,     0, 0, 0, 0),
      entry(CHK_REJECT,  MODE_REQUEST, 7, 3, 255,   255, 255, 255, 255),
      entry(CHK_SAFE_ID, MODE_START,   0, 0, 0,     0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_LD_MAX,  0, 0, 255,   0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_LD_MAX,  7, 3, 255,   0, 0, 0, 0),
      // totals still zero: p0 and p7 can never finish
      entry(CHK_UNSAFE,  MODE_START,   0, 0, 0,     0, 0, 0, 0),
      entry(ROW_TOTALS,  MODE_LD_ALLOC, 0, 0, 0,    255, 255, 255, 255),
      entry(CHK_SAFE_ID, MODE_START,   0, 0, 0,     0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_LD_MAX,  1, 0, 255,   0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_START,   0, 0, 0,     0, 0, 0, 0),
      // granted and safe, then a second grant that leaves both short: rolled back
      entry(CHK_MODEL,   MODE_REQUEST, 0, 0, 0,     100, 0, 0, 0),
      entry(CHK_MODEL,   MODE_REQUEST, 1, 0, 0,     100, 0, 0, 0),
      // allocation above maximum gives a negative need after the next start
      entry(CHK_MODEL,   MODE_LD_ALLOC, 3, 1, 200,  0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_LD_MAX,  3, 1, 100,   0, 0, 0, 0),
      // need is stale until the next start
      entry(CHK_REJECT,  MODE_REQUEST, 3, 1, 0,     0, 1, 0, 0),
      entry(CHK_MODEL,   MODE_START,   0, 0, 0,     0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_REQUEST, 3, 0, 0,     0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_REQUEST, 2, 2, 0,     0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_LD_ALLOC, 0, 0, 0,    0, 0, 0, 0),
      entry(CHK_MODEL,   MODE_LD_ALLOC, 6, 2, 7,    0, 0, 0, 0),
      // totals below the column sums: available goes negative
      entry(ROW_TOTALS,  MODE_LD_ALLOC, 0, 0, 0,    0, 255, 0, 255),
      entry(CHK_MODEL,   MODE_START,   0, 0, 0,     0, 0, 0, 0),
      entry(ROW_TOTALS,  MODE_LD_ALLOC, 0, 0, 0,    170, 85, 60, 200)
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_TOTALS)
        write_totals(plan[i].item.req);
      else
        send_item(plan[i].item, plan[i].kind);
    end

    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      // last stretch runs with both sides always ready
      if (items_sent - rand_start >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      random_phase();
    end

    // drain, then give late or extra results a chance to show
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // run limit far above the slowest correct run
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("ERROR: timeout with %0d results outstanding", pending_verdicts.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
